### rtl/core/stb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank with uptime clock.
// ----------------------------------------------------------------------------
package stb_pkg;

	localparam int TIMERS_DEFAULT = 8;
	localparam int TIMERS_MAX     = 32;

	localparam int ACTION_W = 2;
	localparam int ID_W     = 8;
	localparam int PERIOD_W = 32;
	localparam int MASK_W   = 8;
	localparam int MS_W     = 10;
	localparam int SEC_W    = 12;
	localparam int HOUR_W   = 32;

	localparam int MS_PER_SEC   = 1000;
	localparam int SEC_PER_HOUR = 3600;

	// Action codes of an input item.
	localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ONCE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_AUTO = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_STOP = 2'd3;

	// One decoded command handed to the timer bank in the cycle it takes effect.
	typedef struct packed {
		logic                tick;
		logic                start;
		logic                auto_rl;
		logic                stop;
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
	} cmd_t;

endpackage
`default_nettype wire

### rtl/core/stb_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_in_if
// Valid/ready channel that carries one action item into the timer bank.
// ----------------------------------------------------------------------------
interface stb_in_if;
	logic                          valid;
	logic                          ready;
	logic [stb_pkg::ACTION_W-1:0]  action;
	logic [stb_pkg::ID_W-1:0]      timer_id;
	logic [stb_pkg::PERIOD_W-1:0]  period;

	modport source (output valid, output action, output timer_id, output period, input ready);
	modport sink   (input valid, input action, input timer_id, input period, output ready);
endinterface
`default_nettype wire

### rtl/core/stb_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_out_if
// Valid/ready channel that carries one result item out of the timer bank.
// ----------------------------------------------------------------------------
interface stb_out_if;
	logic                        valid;
	logic                        ready;
	logic [stb_pkg::MASK_W-1:0]  expired_mask;
	logic [stb_pkg::MASK_W-1:0]  done_flags;
	logic                        bad_id;
	logic [stb_pkg::MS_W-1:0]    millis;
	logic [stb_pkg::SEC_W-1:0]   seconds_in_hour;
	logic [stb_pkg::HOUR_W-1:0]  hours;

	modport source (output valid, output expired_mask, output done_flags, output bad_id,
		output millis, output seconds_in_hour, output hours, input ready);
	modport sink   (input valid, input expired_mask, input done_flags, input bad_id,
		input millis, input seconds_in_hour, input hours, output ready);
endinterface
`default_nettype wire

### rtl/core/stb_uptime.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_uptime
// Millisecond / second-in-hour / hour counter advanced by the tick command.
// ----------------------------------------------------------------------------
module stb_uptime (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        tick,
	output logic [stb_pkg::MS_W-1:0]         millis,
	output logic [stb_pkg::SEC_W-1:0]        seconds_in_hour,
	output logic [stb_pkg::HOUR_W-1:0]       hours
);

	logic [stb_pkg::MS_W-1:0]   ms_q;
	logic [stb_pkg::SEC_W-1:0]  sec_q;
	logic [stb_pkg::HOUR_W-1:0] hour_q;

	// The outputs show the count as it stands after this cycle's command.
	always_comb begin
		millis          = ms_q;
		seconds_in_hour = sec_q;
		hours           = hour_q;
		if (tick) begin
			if (ms_q == stb_pkg::MS_W'(stb_pkg::MS_PER_SEC - 1)) begin
				millis = '0;
				if (sec_q == stb_pkg::SEC_W'(stb_pkg::SEC_PER_HOUR - 1)) begin
					seconds_in_hour = '0;
					hours           = hour_q + stb_pkg::HOUR_W'(1);
				end else begin
					seconds_in_hour = sec_q + stb_pkg::SEC_W'(1);
				end
			end else begin
				millis = ms_q + stb_pkg::MS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= '0;
			sec_q  <= '0;
			hour_q <= '0;
		end else begin
			ms_q   <= millis;
			sec_q  <= seconds_in_hour;
			hour_q <= hours;
		end
	end

endmodule
`default_nettype wire

### rtl/core/stb_timer_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stb_timer_bank
// TIMERS parallel countdown timers with one-shot or auto-reload mode.
// ----------------------------------------------------------------------------
module stb_timer_bank #(
	parameter int TIMERS = stb_pkg::TIMERS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire stb_pkg::cmd_t               cmd,
	output logic [stb_pkg::MASK_W-1:0]       expired_mask,
	output logic [stb_pkg::MASK_W-1:0]       done_flags
);

	// Result vectors are padded so that the low eight bits always exist.
	localparam int WIDE = (TIMERS > stb_pkg::MASK_W) ? TIMERS : stb_pkg::MASK_W;

	logic [stb_pkg::PERIOD_W-1:0] remaining_q [TIMERS];
	logic [stb_pkg::PERIOD_W-1:0] reload_q    [TIMERS];
	logic [TIMERS-1:0]            flag_q;
	logic [TIMERS-1:0]            auto_q;

	logic [stb_pkg::PERIOD_W-1:0] remaining_d [TIMERS];
	logic [stb_pkg::PERIOD_W-1:0] reload_d    [TIMERS];
	logic [TIMERS-1:0]            flag_d;
	logic [TIMERS-1:0]            auto_d;
	logic [WIDE-1:0]              exp_w;
	logic [WIDE-1:0]              flag_w;

	always_comb begin
		logic [stb_pkg::PERIOD_W-1:0] dec;
		logic                         hit;
		exp_w  = '0;
		flag_w = '0;
		for (int i = 0; i < TIMERS; i++) begin
			remaining_d[i] = remaining_q[i];
			reload_d[i]    = reload_q[i];
			flag_d[i]      = flag_q[i];
			auto_d[i]      = auto_q[i];
			dec            = remaining_q[i] - stb_pkg::PERIOD_W'(1);
			hit            = (cmd.id == stb_pkg::ID_W'(i));
			if (cmd.tick) begin
				if (remaining_q[i] != '0) begin
					if (dec == '0) begin
						flag_d[i]      = 1'b1;
						exp_w[i]       = 1'b1;
						remaining_d[i] = auto_q[i] ? reload_q[i] : '0;
					end else begin
						remaining_d[i] = dec;
					end
				end
			end else if (cmd.start && hit) begin
				remaining_d[i] = cmd.period;
				reload_d[i]    = cmd.period;
				flag_d[i]      = 1'b0;
				auto_d[i]      = cmd.auto_rl;
			end else if (cmd.stop && hit) begin
				remaining_d[i] = '0;
				flag_d[i]      = 1'b0;
				auto_d[i]      = 1'b0;
			end
			flag_w[i] = flag_d[i];
		end
		expired_mask = exp_w[stb_pkg::MASK_W-1:0];
		done_flags   = flag_w[stb_pkg::MASK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++) begin
				remaining_q[i] <= '0;
				reload_q[i]    <= '0;
			end
			flag_q <= '0;
			auto_q <= '0;
		end else begin
			for (int i = 0; i < TIMERS; i++) begin
				remaining_q[i] <= remaining_d[i];
				reload_q[i]    <= reload_d[i];
			end
			flag_q <= flag_d;
			auto_q <= auto_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/soft_timer_bank_with_uptime_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// soft_timer_bank_with_uptime_top
// Bank of countdown timers sharing a millisecond tick with an uptime clock.
// ----------------------------------------------------------------------------
//
//  Channel  Role     Payload                                   Transfer when
//  -------  -------  ----------------------------------------  --------------------
//  req      sink     action, timer_id, period                  req.valid & req.ready
//  rsp      source   expired_mask, done_flags, bad_id,         rsp.valid & rsp.ready
//                    millis, seconds_in_hour, hours
//
//  Every request gives exactly one response; it passes through the input
//  register and then the result register. One request per cycle is taken
//  sustained while the response side is not stalled.
//  The timer and clock state is updated in the cycle the request leaves the
//  input register, so the next request sees it at once.
//  A stall on rsp holds the result register and then the input register;
//  req.ready falls only when both are full. Reset clears all timers, flags,
//  modes and the uptime clock.
// ----------------------------------------------------------------------------
module soft_timer_bank_with_uptime_top #(
	parameter int TIMERS = stb_pkg::TIMERS_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stb_in_if.sink     req,
	stb_out_if.source  rsp
);

	// Input register.
	logic                          valid_s1;
	logic [stb_pkg::ACTION_W-1:0]  action_s1;
	logic [stb_pkg::ID_W-1:0]      id_s1;
	logic [stb_pkg::PERIOD_W-1:0]  period_s1;

	// Result register.
	logic                          rsp_valid_q;
	logic [stb_pkg::MASK_W-1:0]    mask_q;
	logic [stb_pkg::MASK_W-1:0]    flags_q;
	logic                          bad_q;
	logic [stb_pkg::MS_W-1:0]      ms_q;
	logic [stb_pkg::SEC_W-1:0]     sec_q;
	logic [stb_pkg::HOUR_W-1:0]    hour_q;

	logic                          advance;
	logic                          is_tick;
	logic                          bad_id;
	stb_pkg::cmd_t                 cmd;
	logic [stb_pkg::MASK_W-1:0]    mask_n;
	logic [stb_pkg::MASK_W-1:0]    flags_n;
	logic [stb_pkg::MS_W-1:0]      ms_n;
	logic [stb_pkg::SEC_W-1:0]     sec_n;
	logic [stb_pkg::HOUR_W-1:0]    hour_n;

	// The held request moves on whenever the result register is free or is
	// being emptied in this same cycle; the input register then refills.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign is_tick = (action_s1 == stb_pkg::ACT_TICK);
	// Only start and stop name a timer; a tick never reports a bad id.
	assign bad_id  = !is_tick && (id_s1 >= stb_pkg::ID_W'(TIMERS));

	// Timers beyond the bank never match the id, so a bad id changes nothing.
	always_comb begin
		cmd.tick    = advance && is_tick;
		cmd.start   = advance && ((action_s1 == stb_pkg::ACT_ONCE) ||
			(action_s1 == stb_pkg::ACT_AUTO));
		cmd.auto_rl = (action_s1 == stb_pkg::ACT_AUTO);
		cmd.stop    = advance && (action_s1 == stb_pkg::ACT_STOP);
		cmd.id      = id_s1;
		cmd.period  = period_s1;
	end

	stb_timer_bank #(
		.TIMERS (TIMERS)
	) u_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.expired_mask (mask_n),
		.done_flags   (flags_n)
	);

	stb_uptime u_uptime (
		.clk             (clk),
		.arst_n          (arst_n),
		.tick            (cmd.tick),
		.millis          (ms_n),
		.seconds_in_hour (sec_n),
		.hours           (hour_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1 <= req.action;
			id_s1     <= req.timer_id;
			period_s1 <= req.period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q  <= mask_n;
			flags_q <= flags_n;
			bad_q   <= bad_id;
			ms_q    <= ms_n;
			sec_q   <= sec_n;
			hour_q  <= hour_n;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.expired_mask    = mask_q;
	assign rsp.done_flags      = flags_q;
	assign rsp.bad_id          = bad_q;
	assign rsp.millis          = ms_q;
	assign rsp.seconds_in_hour = sec_q;
	assign rsp.hours           = hour_q;

endmodule
`default_nettype wire
